// File: design/fcull_pkg.sv
// Shared constants, types and result codes for the frustum cull test block.
`timescale 1ns / 1ps

package fcull_pkg;

   localparam int COORD_WIDTH      = 16;
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int PLANE_COUNT      = 6;
   localparam int PLANE_LANE       = 16;
   localparam int PLANE_WIDTH      = 4 * PLANE_LANE;
   localparam int AXIS_COUNT       = 3;
   localparam int OFFSET_LANE      = 3;
   localparam int CSR_INDEX_WIDTH  = $clog2(PLANE_COUNT);
   localparam int RADIUS_WIDTH     = COORD_WIDTH - 1;
   localparam int PROD_WIDTH       = PLANE_LANE + COORD_WIDTH;
   localparam int OFFSET_WIDTH     = PLANE_LANE + NORMAL_FRAC_BITS;
   localparam int RSCALED_WIDTH    = RADIUS_WIDTH + NORMAL_FRAC_BITS + 1;
   localparam int BASE_WIDTH_A     = (PROD_WIDTH > OFFSET_WIDTH) ? PROD_WIDTH : OFFSET_WIDTH;
   localparam int BASE_WIDTH       = (BASE_WIDTH_A > RSCALED_WIDTH) ? BASE_WIDTH_A
                                                                     : RSCALED_WIDTH;
   localparam int DIST_WIDTH       = BASE_WIDTH + 3;

   localparam logic [1:0] ACTION_POINT  = 2'd0;
   localparam logic [1:0] ACTION_SPHERE = 2'd1;
   localparam logic [1:0] ACTION_BOX    = 2'd2;
   localparam logic [1:0] ACTION_NONE   = 2'd3;

   localparam logic [1:0] VERDICT_INSIDE    = 2'd0;
   localparam logic [1:0] VERDICT_INTERSECT = 2'd1;
   localparam logic [1:0] VERDICT_OUTSIDE   = 2'd2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [PLANE_LANE-1:0]  lane_type;
   typedef logic [PLANE_WIDTH-1:0]        plane_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [DIST_WIDTH-1:0]  dist_type;
   typedef logic [RADIUS_WIDTH-1:0]       radius_type;
   typedef logic [CSR_INDEX_WIDTH-1:0]    csr_index_type;

   typedef struct packed {
      logic point_out;
      logic sphere_out;
      logic sphere_int;
      logic box_out;
      logic box_int;
   } plane_flags_type;

endpackage

// File: design/frustum_cull_test_core.sv
// Top level of the six-plane frustum cull test with its three-stage pipeline.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_ready  action, pos_x/y/z, hi_x/y/z, radius
//   rsp       out        rsp_valid / rsp_ready  verdict
//   csr       in         csr_we                 csr_index, csr_wdata (one plane each)
//
// One transaction is accepted per cycle unless a stalled result backs up the pipeline.
// The stages are an input register, a product register with 36 multipliers, and a result
// register fed by the distance sums and sign tests.
// Reset empties the pipeline and clears all six planes to zero.
// A stalled result holds the pipeline; each stage still fills while the one after it is empty.
`timescale 1ns / 1ps

module frustum_cull_test_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_action,
   input  fcull_pkg::coord_type     req_pos_x,
   input  fcull_pkg::coord_type     req_pos_y,
   input  fcull_pkg::coord_type     req_pos_z,
   input  fcull_pkg::coord_type     req_hi_x,
   input  fcull_pkg::coord_type     req_hi_y,
   input  fcull_pkg::coord_type     req_hi_z,
   input  fcull_pkg::radius_type    req_radius,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_verdict,
   input  logic                     csr_we,
   input  fcull_pkg::csr_index_type csr_index,
   input  fcull_pkg::plane_type     csr_wdata
);

   fcull_pkg::plane_type       planes [fcull_pkg::PLANE_COUNT];
   fcull_pkg::plane_flags_type flags [fcull_pkg::PLANE_COUNT];

   logic                  s0_valid_ff;
   logic [1:0]            s0_action_ff;
   fcull_pkg::coord_type  s0_lo_ff [fcull_pkg::AXIS_COUNT];
   fcull_pkg::coord_type  s0_hi_ff [fcull_pkg::AXIS_COUNT];
   fcull_pkg::radius_type s0_radius_ff;
   logic                  s1_valid_ff;
   logic [1:0]            s1_action_ff;
   fcull_pkg::radius_type s1_radius_ff;
   logic                  s2_valid_ff;
   logic [1:0]            s2_verdict_ff;
   logic [1:0]            s2_verdict_in;

   logic s0_load;
   logic s1_load;
   logic s2_load;
   logic any_point_out;
   logic any_sphere_out;
   logic any_sphere_int;
   logic any_box_out;
   logic any_box_int;

   assign s2_load   = !s2_valid_ff || rsp_ready;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign s0_load   = !s0_valid_ff || s1_load;
   assign req_ready = s0_load;

   fcull_plane_regs u_plane_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .planes    (planes)
   );

   for (genvar i = 0; i < fcull_pkg::PLANE_COUNT; i++) begin : g_unit
      fcull_plane_unit u_plane_unit (
         .clock  (clock),
         .enable (s1_load),
         .plane  (planes[i]),
         .lo     (s0_lo_ff),
         .hi     (s0_hi_ff),
         .radius (s1_radius_ff),
         .flags  (flags[i])
      );
   end

   always_comb begin
      any_point_out  = 1'b0;
      any_sphere_out = 1'b0;
      any_sphere_int = 1'b0;
      any_box_out    = 1'b0;
      any_box_int    = 1'b0;
      for (int i = 0; i < fcull_pkg::PLANE_COUNT; i++) begin
         any_point_out  = any_point_out  | flags[i].point_out;
         any_sphere_out = any_sphere_out | flags[i].sphere_out;
         any_sphere_int = any_sphere_int | flags[i].sphere_int;
         any_box_out    = any_box_out    | flags[i].box_out;
         any_box_int    = any_box_int    | flags[i].box_int;
      end

      unique case (s1_action_ff)
         fcull_pkg::ACTION_POINT: begin
            s2_verdict_in = any_point_out ? fcull_pkg::VERDICT_OUTSIDE
                                          : fcull_pkg::VERDICT_INSIDE;
         end
         fcull_pkg::ACTION_SPHERE: begin
            s2_verdict_in = any_sphere_out ? fcull_pkg::VERDICT_OUTSIDE
                          : any_sphere_int ? fcull_pkg::VERDICT_INTERSECT
                                           : fcull_pkg::VERDICT_INSIDE;
         end
         fcull_pkg::ACTION_BOX: begin
            s2_verdict_in = any_box_out ? fcull_pkg::VERDICT_OUTSIDE
                          : any_box_int ? fcull_pkg::VERDICT_INTERSECT
                                        : fcull_pkg::VERDICT_INSIDE;
         end
         fcull_pkg::ACTION_NONE: begin
            s2_verdict_in = fcull_pkg::VERDICT_INSIDE;
         end
         default: begin
            s2_verdict_in = fcull_pkg::VERDICT_INSIDE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s0_load) begin
            s0_valid_ff <= req_valid;
         end
         if (s1_load) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s0_load) begin
         s0_action_ff <= req_action;
         s0_lo_ff[0]  <= req_pos_x;
         s0_lo_ff[1]  <= req_pos_y;
         s0_lo_ff[2]  <= req_pos_z;
         s0_hi_ff[0]  <= req_hi_x;
         s0_hi_ff[1]  <= req_hi_y;
         s0_hi_ff[2]  <= req_hi_z;
         s0_radius_ff <= req_radius;
      end
      if (s1_load) begin
         s1_action_ff <= s0_action_ff;
         s1_radius_ff <= s0_radius_ff;
      end
      if (s2_load) begin
         s2_verdict_ff <= s2_verdict_in;
      end
   end

   assign rsp_valid   = s2_valid_ff;
   assign rsp_verdict = s2_verdict_ff;

endmodule

// File: design/fcull_plane_regs.sv
// Configuration storage for the six frustum planes.
`timescale 1ns / 1ps

module fcull_plane_regs (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  fcull_pkg::csr_index_type csr_index,
   input  fcull_pkg::plane_type     csr_wdata,
   output fcull_pkg::plane_type     planes [fcull_pkg::PLANE_COUNT]
);

   fcull_pkg::plane_type planes_ff [fcull_pkg::PLANE_COUNT];
   fcull_pkg::plane_type planes_in [fcull_pkg::PLANE_COUNT];

   for (genvar i = 0; i < fcull_pkg::PLANE_COUNT; i++) begin : g_plane
      always_comb begin
         if (csr_we && (csr_index == fcull_pkg::CSR_INDEX_WIDTH'(i))) begin
            planes_in[i] = csr_wdata;
         end else begin
            planes_in[i] = planes_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            planes_ff[i] <= '0;
         end else begin
            planes_ff[i] <= planes_in[i];
         end
      end

      assign planes[i] = planes_ff[i];
   end

endmodule

// File: design/fcull_plane_unit.sv
// One plane test: registered products, then distances and sign flags.
`timescale 1ns / 1ps

module fcull_plane_unit (
   input  logic                       clock,
   input  logic                       enable,
   input  fcull_pkg::plane_type       plane,
   input  fcull_pkg::coord_type       lo [fcull_pkg::AXIS_COUNT],
   input  fcull_pkg::coord_type       hi [fcull_pkg::AXIS_COUNT],
   input  fcull_pkg::radius_type      radius,
   output fcull_pkg::plane_flags_type flags
);

   fcull_pkg::prod_type prod_lo_ff [fcull_pkg::AXIS_COUNT];
   fcull_pkg::prod_type prod_lo_in [fcull_pkg::AXIS_COUNT];
   fcull_pkg::prod_type prod_hi_ff [fcull_pkg::AXIS_COUNT];
   fcull_pkg::prod_type prod_hi_in [fcull_pkg::AXIS_COUNT];
   fcull_pkg::lane_type normal [fcull_pkg::AXIS_COUNT];
   fcull_pkg::dist_type offset_scaled;
   fcull_pkg::dist_type radius_scaled;
   fcull_pkg::dist_type dist_lo;
   fcull_pkg::dist_type dist_pv;
   fcull_pkg::dist_type dist_nv;
   fcull_pkg::dist_type dist_plus_r;
   fcull_pkg::dist_type dist_minus_r;

   always_comb begin
      for (int a = 0; a < fcull_pkg::AXIS_COUNT; a++) begin
         normal[a]     = fcull_pkg::lane_type'(plane[a*fcull_pkg::PLANE_LANE +:
                                                     fcull_pkg::PLANE_LANE]);
         prod_lo_in[a] = fcull_pkg::prod_type'(normal[a]) * fcull_pkg::prod_type'(lo[a]);
         prod_hi_in[a] = fcull_pkg::prod_type'(normal[a]) * fcull_pkg::prod_type'(hi[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
   end

   // The corner farthest along the normal takes the maximum where the component is
   // non-negative; the nearest corner takes the other one.
   always_comb begin
      offset_scaled = fcull_pkg::dist_type'(fcull_pkg::lane_type'(
                         plane[fcull_pkg::OFFSET_LANE*fcull_pkg::PLANE_LANE +:
                               fcull_pkg::PLANE_LANE])) <<< fcull_pkg::NORMAL_FRAC_BITS;
      radius_scaled = fcull_pkg::dist_type'(radius) <<< fcull_pkg::NORMAL_FRAC_BITS;
      dist_lo = offset_scaled;
      dist_pv = offset_scaled;
      dist_nv = offset_scaled;
      for (int a = 0; a < fcull_pkg::AXIS_COUNT; a++) begin
         dist_lo = dist_lo + fcull_pkg::dist_type'(prod_lo_ff[a]);
         if (plane[a*fcull_pkg::PLANE_LANE + fcull_pkg::PLANE_LANE - 1]) begin
            dist_pv = dist_pv + fcull_pkg::dist_type'(prod_lo_ff[a]);
            dist_nv = dist_nv + fcull_pkg::dist_type'(prod_hi_ff[a]);
         end else begin
            dist_pv = dist_pv + fcull_pkg::dist_type'(prod_hi_ff[a]);
            dist_nv = dist_nv + fcull_pkg::dist_type'(prod_lo_ff[a]);
         end
      end
      dist_plus_r  = dist_lo + radius_scaled;
      dist_minus_r = dist_lo - radius_scaled;

      flags.point_out  = dist_lo[fcull_pkg::DIST_WIDTH-1];
      flags.sphere_out = dist_plus_r[fcull_pkg::DIST_WIDTH-1];
      flags.sphere_int = dist_minus_r[fcull_pkg::DIST_WIDTH-1];
      flags.box_out    = dist_pv[fcull_pkg::DIST_WIDTH-1];
      flags.box_int    = dist_nv[fcull_pkg::DIST_WIDTH-1];
   end

endmodule

// File: design/fcull_checker.sv
// Port-level assertions for the frustum cull test core and their bind statement.
`timescale 1ns / 1ps

module fcull_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_verdict
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == fcull_pkg::VERDICT_INSIDE ||
                     rsp_verdict == fcull_pkg::VERDICT_INTERSECT ||
                     rsp_verdict == fcull_pkg::VERDICT_OUTSIDE))
      else $error("Result carries an unused verdict code.");

   a_ready_flows: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("Input stalled while the result side is ready.");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("Accepted transaction did not reach the result in three cycles.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_verdict)))
      else $error("Stalled result changed or dropped.");

endmodule

bind frustum_cull_test_core fcull_checker u_fcull_checker (.*);

// File: bench/tb_frustum_cull_test_core.sv
// Self-checking testbench that classifies primitives against loaded frustum planes.
`timescale 1ns / 1ps
module tb_frustum_cull_test_core;
   import fcull_pkg::*;

   localparam int DRAIN_CYCLES  = 12;
   localparam int RANDOM_ROUNDS = 10;
   localparam int ROUND_ITEMS   = 125;
   localparam int UNIT_NORMAL   = 1 << NORMAL_FRAC_BITS;
   localparam int COORD_MAX     = (1 << (COORD_WIDTH - 1)) - 1;
   localparam int COORD_MIN     = -(1 << (COORD_WIDTH - 1));
   localparam int RADIUS_MAX    = (1 << RADIUS_WIDTH) - 1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_PLANE_LEFT,
      REG_PLANE_RIGHT,
      REG_PLANE_TOP,
      REG_PLANE_BOTTOM,
      REG_PLANE_NEAR,
      REG_PLANE_FAR,
      REG_SPARE_A,
      REG_SPARE_B
   } csr_reg_type;

   typedef enum int {
      PLANES_BOX_FRUSTUM,
      PLANES_RANDOM,
      PLANES_EXTREME,
      PLANES_ZERO
   } plane_set_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [1:0] action;
      coord_type  pos_x;
      coord_type  pos_y;
      coord_type  pos_z;
      coord_type  hi_x;
      coord_type  hi_y;
      coord_type  hi_z;
      radius_type radius;
   } primitive_type;

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_valid   = 1'b0;
   logic [1:0]    req_action  = ACTION_POINT;
   coord_type     req_pos_x   = '0;
   coord_type     req_pos_y   = '0;
   coord_type     req_pos_z   = '0;
   coord_type     req_hi_x    = '0;
   coord_type     req_hi_y    = '0;
   coord_type     req_hi_z    = '0;
   radius_type    req_radius  = '0;
   logic          rsp_ready   = 1'b0;
   logic          csr_we      = 1'b0;
   csr_index_type csr_index   = REG_PLANE_LEFT;
   plane_type     csr_wdata   = '0;
   logic          req_ready;
   logic          rsp_valid;
   logic [1:0]    rsp_verdict;

   plane_type  frustum_planes [PLANE_COUNT];
   plane_type  next_planes [PLANE_COUNT];
   logic [1:0] expected_verdicts [$];
   logic [1:0] oldest_verdict;
   int         send_idle_pct      = 0;
   int         rsp_stall_pct      = 0;
   int         verdicts_checked   = 0;
   int         verdict_mismatches = 0;
   int         plane_loads        = 0;
   int         primitives_sent [4] = '{0, 0, 0, 0};

   frustum_cull_test_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_pos_x   (req_pos_x),
      .req_pos_y   (req_pos_y),
      .req_pos_z   (req_pos_z),
      .req_hi_x    (req_hi_x),
      .req_hi_y    (req_hi_y),
      .req_hi_z    (req_hi_z),
      .req_radius  (req_radius),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_verdict (rsp_verdict),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            verdict_mismatches++;
            $display("%0t: unexpected verdict, expected none, actual %0d", $time,
                     rsp_verdict);
         end else begin
            oldest_verdict = expected_verdicts.pop_front();
            verdicts_checked++;
            if (rsp_verdict !== oldest_verdict) begin
               verdict_mismatches++;
               $display("%0t: verdict mismatch, expected %0d, actual %0d", $time,
                        oldest_verdict, rsp_verdict);
            end
         end
      end
   end

   function automatic longint plane_distance(plane_type pl, coord_type x, coord_type y,
                                              coord_type z);
      longint nx, ny, nz, offset;
      nx     = lane_type'(pl[0 +: PLANE_LANE]);
      ny     = lane_type'(pl[PLANE_LANE +: PLANE_LANE]);
      nz     = lane_type'(pl[2 * PLANE_LANE +: PLANE_LANE]);
      offset = lane_type'(pl[OFFSET_LANE * PLANE_LANE +: PLANE_LANE]);
      return nx * x + ny * y + nz * z + (offset <<< NORMAL_FRAC_BITS);
   endfunction

   function automatic logic [1:0] classify_primitive(primitive_type p);
      logic [1:0] verdict;
      longint     radius_q, centre;
      coord_type  far_x, far_y, far_z, near_x, near_y, near_z;
      plane_type  pl;
      verdict  = VERDICT_INSIDE;
      radius_q = longint'(p.radius) <<< NORMAL_FRAC_BITS;
      if (p.action == ACTION_NONE)
         return VERDICT_INSIDE;
      for (int i = 0; i < PLANE_COUNT; i++) begin
         pl = frustum_planes[i];
         if (p.action == ACTION_POINT) begin
            if (plane_distance(pl, p.pos_x, p.pos_y, p.pos_z) < 0)
               return VERDICT_OUTSIDE;
         end else if (p.action == ACTION_SPHERE) begin
            centre = plane_distance(pl, p.pos_x, p.pos_y, p.pos_z);
            if (centre + radius_q < 0)
               return VERDICT_OUTSIDE;
            if (centre - radius_q < 0)
               verdict = VERDICT_INTERSECT;
         end else begin
            // A negative normal component picks the minimum coordinate for the far corner.
            far_x  = pl[PLANE_LANE - 1]     ? p.pos_x : p.hi_x;
            near_x = pl[PLANE_LANE - 1]     ? p.hi_x  : p.pos_x;
            far_y  = pl[2 * PLANE_LANE - 1] ? p.pos_y : p.hi_y;
            near_y = pl[2 * PLANE_LANE - 1] ? p.hi_y  : p.pos_y;
            far_z  = pl[3 * PLANE_LANE - 1] ? p.pos_z : p.hi_z;
            near_z = pl[3 * PLANE_LANE - 1] ? p.hi_z  : p.pos_z;
            if (plane_distance(pl, far_x, far_y, far_z) < 0)
               return VERDICT_OUTSIDE;
            if (plane_distance(pl, near_x, near_y, near_z) < 0)
               verdict = VERDICT_INTERSECT;
         end
      end
      return verdict;
   endfunction

   function automatic plane_type make_plane(int nx, int ny, int nz, int offset);
      return {lane_type'(offset), lane_type'(nz), lane_type'(ny), lane_type'(nx)};
   endfunction

   function automatic primitive_type make_primitive(logic [1:0] action, int x, int y, int z,
                                                    int hx, int hy, int hz, int radius);
      primitive_type p;
      p.action = action;
      p.pos_x  = coord_type'(x);
      p.pos_y  = coord_type'(y);
      p.pos_z  = coord_type'(z);
      p.hi_x   = coord_type'(hx);
      p.hi_y   = coord_type'(hy);
      p.hi_z   = coord_type'(hz);
      p.radius = radius_type'(radius);
      return p;
   endfunction

   function automatic coord_type clamp_coord(int v);
      if (v > COORD_MAX)
         return coord_type'(COORD_MAX);
      if (v < COORD_MIN)
         return coord_type'(COORD_MIN);
      return coord_type'(v);
   endfunction

   function automatic coord_type nearby_coord(int span);
      return clamp_coord(int'($urandom_range(0, 4 * span)) - 2 * span);
   endfunction

   function automatic primitive_type random_primitive(int span);
      primitive_type p;
      logic          wide;
      wide     = ($urandom_range(99) < 15);
      p.action = ($urandom_range(99) < 5) ? ACTION_NONE : 2'($urandom_range(2));
      p.pos_x  = wide ? coord_type'($urandom) : nearby_coord(span);
      p.pos_y  = wide ? coord_type'($urandom) : nearby_coord(span);
      p.pos_z  = wide ? coord_type'($urandom) : nearby_coord(span);
      if (p.action == ACTION_BOX && !wide && $urandom_range(99) >= 10) begin
         p.hi_x = clamp_coord(p.pos_x + int'($urandom_range(0, span)));
         p.hi_y = clamp_coord(p.pos_y + int'($urandom_range(0, span)));
         p.hi_z = clamp_coord(p.pos_z + int'($urandom_range(0, span)));
      end else begin
         p.hi_x = coord_type'($urandom);
         p.hi_y = coord_type'($urandom);
         p.hi_z = coord_type'($urandom);
      end
      p.radius = wide ? radius_type'($urandom) : radius_type'($urandom_range(0, span));
      return p;
   endfunction

   task automatic set_idle(input idle_mode_type mode);
      send_idle_pct = (mode == IDLE_SENDER || mode == IDLE_BOTH) ? 76 : 0;
      rsp_stall_pct = (mode == IDLE_RECEIVER || mode == IDLE_BOTH) ? 76 : 0;
      if (mode == IDLE_BOTH) begin
         send_idle_pct = 18;
         rsp_stall_pct = 18;
      end
   endtask

   task automatic send_primitive(input primitive_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= p.action;
      req_pos_x  <= p.pos_x;
      req_pos_y  <= p.pos_y;
      req_pos_z  <= p.pos_z;
      req_hi_x   <= p.hi_x;
      req_hi_y   <= p.hi_y;
      req_hi_z   <= p.hi_z;
      req_radius <= p.radius;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      expected_verdicts.push_back(classify_primitive(p));
      primitives_sent[p.action]++;
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_planes();
      for (int i = 0; i < PLANE_COUNT; i++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_reg_type'(i);
         csr_wdata <= next_planes[i];
         @(posedge clock);
         frustum_planes[i] = next_planes[i];
      end
      csr_we <= 1'b0;
      plane_loads++;
   endtask

   task automatic build_plane_set(input plane_set_type kind, input int extent, input int tilt);
      int lanes [AXIS_COUNT];
      int pick;
      for (int i = 0; i < PLANE_COUNT; i++) begin
         case (kind)
            PLANES_ZERO: begin
               next_planes[i] = '0;
            end
            PLANES_RANDOM: begin
               next_planes[i] = {$urandom, $urandom};
            end
            PLANES_EXTREME: begin
               for (int k = 0; k < 4; k++) begin
                  pick = $urandom_range(2);
                  next_planes[i][k * PLANE_LANE +: PLANE_LANE] =
                     (pick == 0) ? lane_type'(COORD_MIN) :
                     (pick == 1) ? lane_type'(COORD_MAX) : lane_type'(0);
               end
            end
            default: begin
               // Opposite planes face each other along one axis, enclosing a cube of the extent.
               for (int a = 0; a < AXIS_COUNT; a++) begin
                  lanes[a] = (a == i / 2) ? ((i % 2 == 0) ? UNIT_NORMAL : -UNIT_NORMAL) : 0;
                  if (tilt > 0 && $urandom_range(99) < 70)
                     lanes[a] += int'($urandom_range(0, 2 * tilt)) - tilt;
               end
               next_planes[i] = make_plane(lanes[0], lanes[1], lanes[2], extent);
            end
         endcase
      end
   endtask

   task automatic test_reset_planes();
      set_idle(IDLE_NONE);
      send_primitive(make_primitive(ACTION_POINT, COORD_MAX, COORD_MIN, 5, 0, 0, 0, 0));
      send_primitive(make_primitive(ACTION_SPHERE, 100, -100, 7, 0, 0, 0, 0));
      send_primitive(make_primitive(ACTION_SPHERE, COORD_MIN, COORD_MAX, 0, 0, 0, 0,
                                    RADIUS_MAX));
      send_primitive(make_primitive(ACTION_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                                    COORD_MAX, COORD_MAX, COORD_MAX, 3));
      send_primitive(make_primitive(ACTION_NONE, -1, -1, -1, -1, -1, -1, RADIUS_MAX));
      drain_pipeline();
   endtask

   task automatic test_directed_frustum();
      build_plane_set(PLANES_BOX_FRUSTUM, 1600, 0);
      load_planes();
      @(posedge clock);
      // Writes to the two indexes past the last plane must leave every plane untouched.
      csr_we    <= 1'b1;
      csr_index <= REG_SPARE_A;
      csr_wdata <= {$urandom, $urandom};
      @(posedge clock);
      csr_index <= REG_SPARE_B;
      csr_wdata <= {$urandom, $urandom};
      @(posedge clock);
      csr_we <= 1'b0;
      set_idle(IDLE_BOTH);
      send_primitive(make_primitive(ACTION_POINT, 0, 0, 0, 0, 0, 0, 0));
      send_primitive(make_primitive(ACTION_POINT, 1601, 0, 0, 0, 0, 0, 0));
      send_primitive(make_primitive(ACTION_POINT, 1600, -1600, 1600, 0, 0, 0, 0));
      send_primitive(make_primitive(ACTION_SPHERE, 0, 0, 0, 0, 0, 0, 100));
      send_primitive(make_primitive(ACTION_SPHERE, 1550, 0, 0, 0, 0, 0, 100));
      send_primitive(make_primitive(ACTION_SPHERE, 1750, 0, 0, 0, 0, 0, 100));
      send_primitive(make_primitive(ACTION_SPHERE, 0, 1700, 0, 0, 0, 0, 100));
      send_primitive(make_primitive(ACTION_BOX, -100, -100, -100, 100, 100, 100, 0));
      send_primitive(make_primitive(ACTION_BOX, 1500, 0, 0, 1700, 10, 10, 0));
      send_primitive(make_primitive(ACTION_BOX, 0, 0, 1700, 10, 10, 1800, 0));
      send_primitive(make_primitive(ACTION_BOX, 100, 1700, 100, -100, 1500, -100, 0));
      send_primitive(make_primitive(ACTION_SPHERE, 0, 0, 0, 0, 0, 0, RADIUS_MAX));
      send_primitive(make_primitive(ACTION_NONE, COORD_MAX, COORD_MAX, COORD_MAX,
                                    COORD_MIN, COORD_MIN, COORD_MIN, 0));
      drain_pipeline();
   endtask

   task automatic test_extreme_planes();
      build_plane_set(PLANES_EXTREME, 0, 0);
      next_planes[REG_PLANE_LEFT]  = make_plane(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      next_planes[REG_PLANE_RIGHT] = make_plane(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      load_planes();
      set_idle(IDLE_RECEIVER);
      send_primitive(make_primitive(ACTION_POINT, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0));
      send_primitive(make_primitive(ACTION_POINT, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0, 0));
      send_primitive(make_primitive(ACTION_SPHERE, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0,
                                    RADIUS_MAX));
      send_primitive(make_primitive(ACTION_BOX, COORD_MIN, COORD_MIN, COORD_MIN,
                                    COORD_MAX, COORD_MAX, COORD_MAX, 0));
      send_primitive(make_primitive(ACTION_BOX, COORD_MAX, COORD_MAX, COORD_MAX,
                                    COORD_MIN, COORD_MIN, COORD_MIN, 0));
      drain_pipeline();
   endtask

   task automatic test_random_culling();
      plane_set_type kind;
      int            extent;
      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         kind   = (round % 2 == 0) ? PLANES_BOX_FRUSTUM : plane_set_type'((round / 2) % 3 + 1);
         extent = (kind == PLANES_BOX_FRUSTUM) ? int'($urandom_range(16, 12000)) : 4096;
         build_plane_set(kind, extent, 1500);
         load_planes();
         set_idle(idle_mode_type'((round + round / 2) % 4));
         repeat (ROUND_ITEMS) send_primitive(random_primitive(extent));
         drain_pipeline();
      end
   endtask

   initial begin
      for (int i = 0; i < PLANE_COUNT; i++)
         frustum_planes[i] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_planes();
      test_directed_frustum();
      test_extreme_planes();
      test_random_culling();
      $display("Classified %0d points, %0d spheres, %0d boxes and %0d unused selectors.",
               primitives_sent[ACTION_POINT], primitives_sent[ACTION_SPHERE],
               primitives_sent[ACTION_BOX], primitives_sent[ACTION_NONE]);
      $display("Checked %0d verdicts over %0d plane sets under four idle patterns.",
               verdicts_checked, plane_loads);
      if (verdict_mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2000000;
      $display("Run did not finish within the time limit.");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
